FILE: hdl/multilevel_fifo_ready_queue_assert.svh
// assertion helpers for the checks in the top-level ready queue
`ifndef MULTILEVEL_FIFO_READY_QUEUE_ASSERT_SVH
`define MULTILEVEL_FIFO_READY_QUEUE_ASSERT_SVH

// same-cycle implication
`define MFRQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MFRQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mfrq_pkg.sv
package mfrq_pkg;

    localparam int ID_W  = 4;
    localparam int LVL_W = 3;
    localparam int OPC_W = 3;
    localparam int ST_W  = 2;

    localparam logic [OPC_W-1:0] OPC_ADD  = 3'd0;
    localparam logic [OPC_W-1:0] OPC_POP  = 3'd1;
    localparam logic [OPC_W-1:0] OPC_PEEK = 3'd2;
    localparam logic [OPC_W-1:0] OPC_SET  = 3'd3;
    localparam logic [OPC_W-1:0] OPC_GET  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

    localparam logic [LVL_W-1:0] SET_MAX_LEVEL = 3'd3;

    typedef struct packed {
        logic [OPC_W-1:0] opcode;
        logic             queue_sel;
        logic [ID_W-1:0]  task_id;
        logic [LVL_W-1:0] level;
    } req_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [ID_W-1:0]  out_id;
        logic [LVL_W-1:0] out_level;
    } rsp_t;

    typedef enum logic [4:0] {
        DP_NONE,
        DP_LOAD,
        DP_STATUS,
        DP_ADD,
        DP_HEAD_READ,
        DP_CAPT_HEAD,
        DP_LVL_READ,
        DP_CAPT_GET,
        DP_SET_START,
        DP_SCAN_READ,
        DP_POS_INC,
        DP_SHIFT_READ,
        DP_SHIFT_WRITE,
        DP_COUNT_DEC,
        DP_APPEND,
        DP_NEXT_TABLE,
        DP_PUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t          op;
        logic [ST_W-1:0] st;
    } dp_cmd_t;

    typedef struct packed {
        logic [OPC_W-1:0] opcode;
        logic             add_bad;
        logic             set_bad;
        logic             get_bad;
        logic             tgt_full;
        logic             nonempty;
        logic             same_level;
        logic             scan_more;
        logic             hit;
        logic             shift_more;
        logic             tbl_last;
        logic             out_free;
    } dp_stat_t;

endpackage

FILE: hdl/mfrq_ram.sv
module mfrq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/mfrq_ctrl.sv
module mfrq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  mfrq_pkg::dp_stat_t stat,
    output mfrq_pkg::dp_cmd_t  cmd
);
    import mfrq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_HEAD,
        S_GET_LVL,
        S_SET_LVL,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_APPEND,
        S_NEXT_TBL,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = DP_NONE;
        cmd.st     = ST_OK;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                case (stat.opcode)
                    OPC_ADD:
                    begin
                        if (stat.add_bad)
                        begin
                            cmd.op = DP_STATUS;
                            cmd.st = ST_INVALID;
                        end
                        else if (stat.tgt_full)
                        begin
                            cmd.op = DP_STATUS;
                            cmd.st = ST_FULL;
                        end
                        else
                        begin
                            cmd.op = DP_ADD;
                        end
                    end
                    OPC_POP, OPC_PEEK:
                    begin
                        if (!stat.nonempty)
                        begin
                            cmd.op = DP_STATUS;
                            cmd.st = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.op     = DP_HEAD_READ;
                            state_next = S_HEAD;
                        end
                    end
                    OPC_SET:
                    begin
                        if (stat.set_bad)
                        begin
                            cmd.op = DP_STATUS;
                            cmd.st = ST_INVALID;
                        end
                        else
                        begin
                            cmd.op     = DP_LVL_READ;
                            state_next = S_SET_LVL;
                        end
                    end
                    OPC_GET:
                    begin
                        if (stat.get_bad)
                        begin
                            cmd.op = DP_STATUS;
                            cmd.st = ST_INVALID;
                        end
                        else
                        begin
                            cmd.op     = DP_LVL_READ;
                            state_next = S_GET_LVL;
                        end
                    end
                    default:
                    begin
                        cmd.op = DP_STATUS;
                        cmd.st = ST_INVALID;
                    end
                endcase
            end
            S_HEAD:
            begin
                cmd.op     = DP_CAPT_HEAD;
                state_next = (stat.opcode == OPC_PEEK) ? S_FINISH : S_SHIFT_RD;
            end
            S_GET_LVL:
            begin
                cmd.op     = DP_CAPT_GET;
                state_next = S_FINISH;
            end
            S_SET_LVL:
            begin
                if (stat.same_level)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.op     = DP_SET_START;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (stat.scan_more)
                begin
                    cmd.op     = DP_SCAN_READ;
                    state_next = S_SCAN_CHK;
                end
                else
                begin
                    state_next = S_NEXT_TBL;
                end
            end
            S_SCAN_CHK:
            begin
                if (stat.hit)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    cmd.op     = DP_POS_INC;
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (stat.shift_more)
                begin
                    cmd.op     = DP_SHIFT_READ;
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    cmd.op     = DP_COUNT_DEC;
                    state_next = (stat.opcode == OPC_POP) ? S_FINISH : S_APPEND;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.op     = DP_SHIFT_WRITE;
                state_next = S_SHIFT_RD;
            end
            S_APPEND:
            begin
                if (stat.tgt_full)
                begin
                    cmd.op = DP_STATUS;
                    cmd.st = ST_FULL;
                end
                else
                begin
                    cmd.op = DP_APPEND;
                end
                state_next = S_NEXT_TBL;
            end
            S_NEXT_TBL:
            begin
                if (stat.tbl_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.op     = DP_NEXT_TABLE;
                    state_next = S_SCAN_RD;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = DP_PUSH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hdl/mfrq_dp.sv
module mfrq_dp #(
    parameter int MAX_TASKS = 16,
    parameter int LEVELS    = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mfrq_pkg::dp_cmd_t  cmd,
    input  mfrq_pkg::req_t     req,
    output mfrq_pkg::dp_stat_t stat,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output mfrq_pkg::rsp_t     rsp
);
    import mfrq_pkg::*;

    localparam int PW    = $clog2(MAX_TASKS);
    localparam int CW    = $clog2(MAX_TASKS + 1);
    localparam int LW    = $clog2(LEVELS);
    localparam int AW    = $clog2(2 * LEVELS * MAX_TASKS);
    localparam int CMPW  = (CW > ID_W) ? CW : ID_W;
    localparam int LVCW  = LVL_W + 1;

    req_t              req_reg;
    req_t              req_next;
    rsp_t              res_reg;
    rsp_t              res_next;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    logic              tbl_reg;
    logic              tbl_next;
    logic [LW-1:0]     wl_reg;
    logic [LW-1:0]     wl_next;
    logic [LW-1:0]     old_reg;
    logic [LW-1:0]     old_next;
    logic [CW-1:0]     pos_reg;
    logic [CW-1:0]     pos_next;
    logic [CW-1:0]     cnt_reg  [2][LEVELS];
    logic [CW-1:0]     cnt_next [2][LEVELS];
    logic [MAX_TASKS-1:0] lvl_vld_reg;
    logic [MAX_TASKS-1:0] lvl_vld_next;

    logic [PW-1:0]     id_idx;
    logic              id_big;
    logic              lv_big;
    logic              req_lv_ok;
    logic [LW-1:0]     lv_clamp;
    logic [CW-1:0]     cnt_cur;
    logic [CW-1:0]     pos_p1;
    logic [LW-1:0]     hi;
    logic              nonempty;
    logic [LVL_W-1:0]  lvl_val;

    logic              slot_we;
    logic [AW-1:0]     slot_waddr;
    logic [ID_W-1:0]   slot_wdata;
    logic              slot_re;
    logic [AW-1:0]     slot_raddr;
    logic [ID_W-1:0]   slot_rdata;
    logic              lvl_we;
    logic              lvl_re;
    logic [LVL_W-1:0]  lvl_rdata;

    function automatic logic [AW-1:0] slot_addr(input logic t, input logic [LW-1:0] lv,
                                                input logic [PW-1:0] p);
        logic [AW-1:0] row;
        row = AW'(t) * AW'(LEVELS) + AW'(lv);
        return row * AW'(MAX_TASKS) + AW'(p);
    endfunction

    // task id and level checks
    assign id_idx    = PW'(req_reg.task_id);
    assign id_big    = CMPW'(req_reg.task_id) >= CMPW'(MAX_TASKS);
    assign lv_big    = {1'b0, req_reg.level} >= LVCW'(LEVELS);
    assign req_lv_ok = {1'b0, req.level} < LVCW'(LEVELS);
    assign lv_clamp  = lv_big ? '0 : LW'(req_reg.level);

    assign cnt_cur = cnt_reg[tbl_reg][wl_reg];
    assign pos_p1  = pos_reg + CW'(1);
    assign lvl_val = lvl_vld_reg[id_idx] ? lvl_rdata : LVL_W'(LEVELS - 1);

    // highest non-empty level of the current table
    always_comb
    begin
        hi       = '0;
        nonempty = 1'b0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (cnt_reg[tbl_reg][i] != '0)
            begin
                hi       = LW'(i);
                nonempty = 1'b1;
            end
        end
    end

    always_comb
    begin
        stat.opcode     = req_reg.opcode;
        stat.add_bad    = id_big || lv_big;
        stat.get_bad    = id_big;
        stat.set_bad    = id_big || (req_reg.task_id == '0) || lv_big
                          || (req_reg.level > SET_MAX_LEVEL);
        stat.tgt_full   = cnt_cur == CW'(MAX_TASKS);
        stat.nonempty   = nonempty;
        stat.same_level = lvl_val == req_reg.level;
        stat.scan_more  = pos_reg < cnt_cur;
        stat.hit        = slot_rdata == req_reg.task_id;
        stat.shift_more = pos_p1 < cnt_cur;
        stat.tbl_last   = tbl_reg;
        stat.out_free   = !rsp_valid_reg || rsp_ready;
    end

    // slot memory access
    always_comb
    begin
        slot_we    = (cmd.op == DP_ADD) || (cmd.op == DP_APPEND) || (cmd.op == DP_SHIFT_WRITE);
        slot_waddr = slot_addr(tbl_reg, wl_reg, cnt_cur[PW-1:0]);
        slot_wdata = req_reg.task_id;
        if (cmd.op == DP_SHIFT_WRITE)
        begin
            slot_waddr = slot_addr(tbl_reg, wl_reg, pos_reg[PW-1:0]);
            slot_wdata = slot_rdata;
        end
        slot_re = (cmd.op == DP_HEAD_READ) || (cmd.op == DP_SCAN_READ)
                  || (cmd.op == DP_SHIFT_READ);
        case (cmd.op)
            DP_HEAD_READ:  slot_raddr = slot_addr(tbl_reg, hi, '0);
            DP_SHIFT_READ: slot_raddr = slot_addr(tbl_reg, wl_reg, pos_p1[PW-1:0]);
            default:       slot_raddr = slot_addr(tbl_reg, wl_reg, pos_reg[PW-1:0]);
        endcase
    end

    assign lvl_we = (cmd.op == DP_ADD) || (cmd.op == DP_SET_START);
    assign lvl_re = cmd.op == DP_LVL_READ;

    always_comb
    begin
        req_next       = req_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        tbl_next       = tbl_reg;
        wl_next        = wl_reg;
        old_next       = old_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        lvl_vld_next   = lvl_vld_reg;
        case (cmd.op)
            DP_LOAD:
            begin
                req_next = req;
                res_next = '{status: ST_OK, out_id: '0, out_level: '0};
                tbl_next = (req.opcode == OPC_PEEK) ? 1'b0 : req.queue_sel;
                wl_next  = req_lv_ok ? LW'(req.level) : '0;
                pos_next = '0;
            end
            DP_STATUS:
            begin
                res_next.status = cmd.st;
            end
            DP_ADD:
            begin
                cnt_next[tbl_reg][wl_reg] = cnt_cur + CW'(1);
                lvl_vld_next[id_idx]      = 1'b1;
            end
            DP_HEAD_READ:
            begin
                wl_next  = hi;
                pos_next = '0;
            end
            DP_CAPT_HEAD:
            begin
                res_next.out_id    = slot_rdata;
                res_next.out_level = LVL_W'(wl_reg);
            end
            DP_CAPT_GET:
            begin
                res_next.out_level = lvl_val;
            end
            DP_SET_START:
            begin
                wl_next              = LW'(lvl_val);
                old_next             = LW'(lvl_val);
                tbl_next             = 1'b0;
                pos_next             = '0;
                lvl_vld_next[id_idx] = 1'b1;
            end
            DP_POS_INC, DP_SHIFT_WRITE:
            begin
                pos_next = pos_p1;
            end
            DP_COUNT_DEC:
            begin
                cnt_next[tbl_reg][wl_reg] = cnt_cur - CW'(1);
                wl_next                   = lv_clamp;
            end
            DP_APPEND:
            begin
                cnt_next[tbl_reg][wl_reg] = cnt_cur + CW'(1);
            end
            DP_NEXT_TABLE:
            begin
                tbl_next = 1'b1;
                wl_next  = old_reg;
                pos_next = '0;
            end
            DP_PUSH:
            begin
                rsp_next       = res_reg;
                rsp_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            tbl_reg       <= 1'b0;
            wl_reg        <= '0;
            old_reg       <= '0;
            pos_reg       <= '0;
            cnt_reg       <= '{default: '0};
            lvl_vld_reg   <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            tbl_reg       <= tbl_next;
            wl_reg        <= wl_next;
            old_reg       <= old_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            lvl_vld_reg   <= lvl_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // task ids of both tables, one row of MAX_TASKS per level
    mfrq_ram #(
        .WIDTH (ID_W),
        .DEPTH (2 * LEVELS * MAX_TASKS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // per-task level, unwritten entries read as the lowest level
    mfrq_ram #(
        .WIDTH (LVL_W),
        .DEPTH (MAX_TASKS)
    ) u_lvl_ram (
        .clk   (clk),
        .we    (lvl_we),
        .waddr (id_idx),
        .wdata (req_reg.level),
        .re    (lvl_re),
        .raddr (id_idx),
        .rdata (lvl_rdata)
    );

endmodule

FILE: hdl/multilevel_fifo_ready_queue.sv
// channel | valid     | ready     | payload
// request | req_valid | req_ready | req (opcode, queue_sel, task_id, level)
// result  | rsp_valid | rsp_ready | rsp (status, out_id, out_level)
//
// one request at a time
// pop reads the head, then moves each entry behind it forward with a slot ram read and a write
// set priority scans the old level of each table and moves a task it finds there to the new level
// no clearing pass after reset: level counts and per-task valid bits reset at once
// a finished result waits in the output register; the next request is taken meanwhile
`include "multilevel_fifo_ready_queue_assert.svh"

module multilevel_fifo_ready_queue #(
    parameter int MAX_TASKS = 16,
    parameter int LEVELS    = 5
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  mfrq_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output mfrq_pkg::rsp_t rsp
);
    import mfrq_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    mfrq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    mfrq_dp #(
        .MAX_TASKS (MAX_TASKS),
        .LEVELS    (LEVELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .req       (req),
        .stat      (dp_stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    `MFRQ_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready,
        "request taken while previous item still in progress")
    `MFRQ_ASSERT_NOW(a_rsp_from_work, $rose(rsp_valid), !$past(req_ready),
        "result appeared without an item in progress")
    `MFRQ_ASSERT_NOW(a_fail_clean,
        rsp_valid && (rsp.status == ST_EMPTY || rsp.status == ST_INVALID),
        rsp.out_id == '0 && rsp.out_level == '0,
        "failed item returned a nonzero id or level")

endmodule
